FILE: rtl/core/particle_sensor_frame_parser_defines.svh
// Assertion macros shared by the frame parser RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef PARTICLE_SENSOR_FRAME_PARSER_DEFINES_SVH
`define PARTICLE_SENSOR_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PSFP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PSFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/psfp_pkg.sv
// Types and constants of the particle sensor frame parser.
// Used by the parser, the result register and the top level.
package psfp_pkg;

  localparam int unsigned POS_W = 7;

  localparam logic [7:0] HDR_ZERO   = 8'h00;
  localparam logic [7:0] HDR_SINGLE = 8'h40;
  localparam logic [7:0] HDR_AUTO_A = 8'h42;
  localparam logic [7:0] HDR_AUTO_B = 8'h4D;
  localparam logic [7:0] HDR_ACK    = 8'hA5;
  localparam logic [7:0] HDR_REFUSE = 8'h96;

  localparam logic [POS_W-1:0] SINGLE_VALUE_POS = 7'd3;
  localparam logic [POS_W-1:0] AUTO_VALUE_POS   = 7'd6;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_REFUSE = 2'd1,
    KIND_SINGLE = 2'd2,
    KIND_AUTO   = 2'd3
  } event_kind_t;

  typedef enum logic [4:0] {
    PH_HUNT      = 5'b00001,
    PH_SECOND    = 5'b00010,
    PH_SINGLE    = 5'b00100,
    PH_AUTO_LEN  = 5'b01000,
    PH_AUTO_BODY = 5'b10000
  } phase_t;

  typedef struct packed {
    logic        valid;
    event_kind_t kind;
    logic [15:0] fine;
    logic [15:0] coarse;
  } result_t;

endpackage

FILE: rtl/core/psfp_parser.sv
// Frame parser state machine: takes one byte per advance and updates all state.
// Depends on psfp_pkg and the assertion macro header.
`include "particle_sensor_frame_parser_defines.svh"

module psfp_parser import psfp_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] rx_byte,
  output result_t    res
);

  localparam logic [16:0] MAX_BYTES = 17'(MAX_FRAME_BYTES);

  phase_t           phase, phase_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [15:0]      len, len_next;
  logic [15:0]      sum, sum_next;
  logic [15:0]      rcv_sum, rcv_sum_next;
  logic [15:0]      fine, fine_next;
  logic [15:0]      coarse, coarse_next;
  logic [7:0]       first, first_next;
  logic             seen, seen_next;

  logic [16:0] pos_ext;
  logic [16:0] len_ext;
  logic [15:0] auto_len;
  logic [15:0] rcv_final;
  logic [31:0] cap;

  function automatic logic [31:0] capture_value(
    input logic [POS_W-1:0] p,
    input logic [POS_W-1:0] base,
    input logic [7:0]       b,
    input logic [15:0]      f,
    input logic [15:0]      c
  );
    logic [15:0] nf;
    logic [15:0] nc;
    nf = f;
    nc = c;
    if (p == base) begin
      nf = {b, f[7:0]};
    end else if (p == base + 7'd1) begin
      nf = {f[15:8], b};
    end else if (p == base + 7'd2) begin
      nc = {b, c[7:0]};
    end else if (p == base + 7'd3) begin
      nc = {c[15:8], b};
    end
    return {nf, nc};
  endfunction

  always_comb begin
    phase_next   = phase;
    pos_next     = pos;
    len_next     = len;
    sum_next     = sum;
    rcv_sum_next = rcv_sum;
    fine_next    = fine;
    coarse_next  = coarse;
    first_next   = first;
    seen_next    = seen;
    res          = '0;
    pos_ext      = {10'd0, pos};
    len_ext      = {1'b0, len};
    auto_len     = {len[15:8], rx_byte};
    rcv_final    = {rcv_sum[15:8], rx_byte};
    cap          = {fine, coarse};
    case (phase)
      PH_HUNT: begin
        if (rx_byte == HDR_ZERO && pos == '0) begin
          pos_next = 7'd1;
        end else begin
          first_next = rx_byte;
          phase_next = PH_SECOND;
          pos_next   = 7'd2;
        end
      end
      PH_SECOND: begin
        sum_next     = {8'd0, first} + {8'd0, rx_byte};
        fine_next    = '0;
        coarse_next  = '0;
        rcv_sum_next = '0;
        phase_next   = PH_HUNT;
        pos_next     = '0;
        if (first == HDR_SINGLE) begin
          len_next = {8'd0, rx_byte};
          if ({9'd0, rx_byte} + 17'd3 <= MAX_BYTES) begin
            phase_next = PH_SINGLE;
            pos_next   = 7'd2;
          end
        end else if (first == HDR_AUTO_A && rx_byte == HDR_AUTO_B) begin
          phase_next = PH_AUTO_LEN;
          pos_next   = 7'd2;
        end else if (first == HDR_ACK && rx_byte == HDR_ACK) begin
          res.valid = 1'b1;
          res.kind  = KIND_ACK;
          seen_next = 1'b1;
        end else if (first == HDR_REFUSE && rx_byte == HDR_REFUSE) begin
          res.valid = 1'b1;
          res.kind  = KIND_REFUSE;
          seen_next = 1'b1;
        end
      end
      PH_SINGLE: begin
        if (pos_ext <= len_ext + 17'd1) begin
          sum_next = sum + {8'd0, rx_byte};
        end
        cap         = capture_value(pos, SINGLE_VALUE_POS, rx_byte, fine, coarse);
        fine_next   = cap[31:16];
        coarse_next = cap[15:0];
        if (pos_ext >= len_ext + 17'd2) begin
          phase_next = PH_HUNT;
          pos_next   = '0;
          if (8'(~sum_next[7:0] + 8'd1) == rx_byte) begin
            res.valid  = 1'b1;
            res.kind   = KIND_SINGLE;
            res.fine   = cap[31:16];
            res.coarse = cap[15:0];
            seen_next  = 1'b1;
          end
        end else begin
          pos_next = pos + 7'd1;
        end
      end
      PH_AUTO_LEN: begin
        sum_next = sum + {8'd0, rx_byte};
        if (pos == 7'd2) begin
          len_next = {rx_byte, 8'd0};
          pos_next = 7'd3;
        end else begin
          len_next = auto_len;
          if (auto_len < 16'd2 || {1'b0, auto_len} + 17'd4 > MAX_BYTES) begin
            phase_next = PH_HUNT;
            pos_next   = '0;
          end else begin
            phase_next = PH_AUTO_BODY;
            pos_next   = 7'd4;
          end
        end
      end
      PH_AUTO_BODY: begin
        if (pos_ext <= len_ext + 17'd1) begin
          sum_next = sum + {8'd0, rx_byte};
        end
        cap         = capture_value(pos, AUTO_VALUE_POS, rx_byte, fine, coarse);
        fine_next   = cap[31:16];
        coarse_next = cap[15:0];
        if (pos_ext == len_ext + 17'd2) begin
          rcv_sum_next = {rx_byte, 8'd0};
        end
        if (pos_ext >= len_ext + 17'd3) begin
          rcv_sum_next = rcv_final;
          phase_next   = PH_HUNT;
          pos_next     = '0;
          if (rcv_final == sum_next &&
              !(cap[31:16] == 16'd0 && cap[15:0] == 16'd0 && !seen)) begin
            res.valid  = 1'b1;
            res.kind   = KIND_AUTO;
            res.fine   = cap[31:16];
            res.coarse = cap[15:0];
            seen_next  = 1'b1;
          end
        end else begin
          pos_next = pos + 7'd1;
        end
      end
      default: begin
        phase_next = PH_HUNT;
        pos_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HUNT;
      pos     <= '0;
      len     <= '0;
      sum     <= '0;
      rcv_sum <= '0;
      fine    <= '0;
      coarse  <= '0;
      first   <= '0;
      seen    <= 1'b0;
    end else if (advance) begin
      phase   <= phase_next;
      pos     <= pos_next;
      len     <= len_next;
      sum     <= sum_next;
      rcv_sum <= rcv_sum_next;
      fine    <= fine_next;
      coarse  <= coarse_next;
      first   <= first_next;
      seen    <= seen_next;
    end
  end

  `PSFP_ASSERT_NEXT(a_emit_rehunt, clk, rst, advance && res.valid,
    phase == PH_HUNT && pos == '0 && seen, "result did not return parser to hunt")
  `PSFP_ASSERT_NOW(a_auto_zero_drop, clk, rst, res.valid && res.kind == KIND_AUTO,
    res.fine != 16'd0 || res.coarse != 16'd0 || seen, "initial zero auto frame reported")
  `PSFP_ASSERT_NOW(a_ack_zero, clk, rst,
    res.valid && (res.kind == KIND_ACK || res.kind == KIND_REFUSE),
    res.fine == 16'd0 && res.coarse == 16'd0, "acknowledge carries values")

endmodule

FILE: rtl/core/psfp_out_reg.sv
// Result register of the frame parser: holds one event until it is taken.
// Depends on psfp_pkg and the assertion macro header.
`include "particle_sensor_frame_parser_defines.svh"

module psfp_out_reg import psfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     res,
  input  logic        event_stall,
  output logic        space,
  output logic        event_valid,
  output logic [1:0]  event_kind,
  output logic [15:0] fine_particles,
  output logic [15:0] coarse_particles
);

  event_kind_t kind;

  assign space      = !event_valid || !event_stall;
  assign event_kind = kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (load) begin
      event_valid <= 1'b1;
    end else if (!event_stall) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind             <= res.kind;
      fine_particles   <= res.fine;
      coarse_particles <= res.coarse;
    end
  end

  `PSFP_ASSERT_NOW(a_no_overwrite, clk, rst, event_valid && event_stall, !load,
    "held event overwritten")

endmodule

FILE: rtl/core/particle_sensor_frame_parser.sv
// Particle sensor frame parser. Takes one received byte per cycle on the rx
// channel and reports acknowledge, refusal, single-read and auto-send value
// frames on the event channel. A byte passes an input register, then the
// parser updates its state and loads any event into the result register.
// The sustained rate is one byte per cycle; the rx side stalls only while the
// result register holds an event that the event side is stalling.
// Depends on psfp_pkg, psfp_parser, psfp_out_reg and the assertion macro header.
`include "particle_sensor_frame_parser_defines.svh"

module particle_sensor_frame_parser import psfp_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        event_valid,
  input  logic        event_stall,
  output logic [1:0]  event_kind,
  output logic [15:0] fine_particles,
  output logic [15:0] coarse_particles
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       space;
  logic       advance;
  logic       take;
  result_t    res;

  assign advance  = held_valid && space;
  assign rx_stall = held_valid && !space;
  assign take     = rx_valid && !rx_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_byte <= rx_byte;
    end
  end

  psfp_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .advance(advance),
    .rx_byte(held_byte),
    .res    (res)
  );

  psfp_out_reg u_out (
    .clk             (clk),
    .rst             (rst),
    .load            (advance && res.valid),
    .res             (res),
    .event_stall     (event_stall),
    .space           (space),
    .event_valid     (event_valid),
    .event_kind      (event_kind),
    .fine_particles  (fine_particles),
    .coarse_particles(coarse_particles)
  );

  `PSFP_ASSERT_NEXT(a_held_kept, clk, rst, held_valid && !space,
    held_valid && $stable(held_byte), "held byte lost while blocked")

endmodule
